/* rtl/core/cacc_pkg.sv */
// Shared constants, widths and helpers for the charger current controller.
package cacc_pkg;
   localparam int SHUTDOWN_DELAY_MS   = 60000;
   localparam int REQUEST_INTERVAL_MS = 2500;
   localparam int COUNT_RELOAD        = 10;
   localparam int VOLTAGE_PERIOD_MS   = 60000;
   localparam int INVERTER_BLOCK_MS   = 1000;
   localparam int SWITCH_ON_CA        = 75;
   localparam int EMERGENCY_CLEAR_CA  = 100;

   localparam int DIV_NUM_W = 30;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_OPTIONS   = 3'd1;
   localparam logic [2:0] CSR_VSET      = 3'd2;
   localparam logic [2:0] CSR_REEN_V    = 3'd3;
   localparam logic [2:0] CSR_TARGET    = 3'd4;
   localparam logic [2:0] CSR_LOWER     = 3'd5;
   localparam logic [2:0] CSR_UPPER     = 3'd6;
   localparam logic [2:0] CSR_STOP_LVL  = 3'd7;

   localparam logic CMD_VOLTAGE = 1'b0;
   localparam logic CMD_CURRENT = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   // a later than b, wrap-safe
   function automatic logic later(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction
endpackage

/* rtl/core/cacc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module cacc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  cacc_pkg::div_req_type         req,
   output logic                          done,
   output logic [cacc_pkg::DIV_NUM_W-1:0] quo
);
   import cacc_pkg::*;

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* rtl/core/charger_auto_current_control.sv */
// Top level: tick sequencer, timers, switch state and result buffer.
// Accept to first result beat: S_PRE, then S_OUT when there is no division; S_TDIV and
// S_LIM come between after the power-limit division; S_MUL, S_CSTRT, S_CDIV and S_FIN
// on the emergency path and when regulation divides for current (30-step divisions).
// One tick at a time: next beat taken the cycle after the last result.
// Reset (synchronous): configuration, timers, flags and counters to zero, stop level 100, switch off.
module charger_auto_current_control (
   input  logic         clock,
   input  logic         reset,
   // now_ms, out_voltage_cv, out_current_ca, out_power_w, efficiency_pm,
   // meter_power_w, meter_stamp_ms, inverter_active, urgent_request,
   // charge_level, bms_limit_ca, bms_current_ca (lowest bits first)
   input  logic [191:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // setpoint, power_on (lowest bits first)
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tuser,   // command
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import cacc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRE   = 4'd1;
   localparam logic [3:0] S_TDIV  = 4'd2;
   localparam logic [3:0] S_LIM   = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_CSTRT = 4'd5;
   localparam logic [3:0] S_CDIV  = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   // configuration
   logic [1:0]  mode_ff, opt_ff;
   logic [15:0] vset_ff, reen_ff, lower_ff, upper_ff;
   logic signed [15:0] target_ff;
   logic [6:0]  stop_ff;

   // latched tick fields
   logic [31:0] now_ff, stamp_ff;
   logic [15:0] volt_ff, cur_ff, opow_ff, bmslim_ff;
   logic [9:0]  effm_ff;
   logic signed [23:0] meter_ff;
   logic        inv_ff, urg_ff;
   logic [6:0]  level_ff;
   logic signed [16:0] bmscur_ff;

   // state
   logic [31:0] since_ff, since_in, nextv_ff, nextv_in, blk_ff, blk_in, lastm_ff, lastm_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        emg_ff, emg_in, sw_ff, sw_in;
   logic [3:0]  st_ff, st_in;
   logic        epath_ff, epath_in;     // emergency current path
   logic        tneg_ff, tneg_in;       // sign of the power-limit division
   logic [15:0] mulb_ff, mulb_in;
   logic [25:0] prod_ff, prod_in;

   // result buffer
   logic        rcmd_ff [2];
   logic [15:0] rsp_ff  [2];
   logic        rpw_ff  [2];
   logic        rcmd_in [2];
   logic [15:0] rsp_in  [2];
   logic        rpw_in  [2];
   logic [1:0]  rn_ff, rn_in;
   logic        rd_ff, rd_in;

   div_req_type          dreq;
   logic                 ddone;
   logic [DIV_NUM_W-1:0] dquo;

   logic [9:0]  eff;
   logic        acc;
   logic        snd;
   logic signed [31:0] sval;
   logic [15:0] sclamp;
   logic signed [27:0] qs, limit;
   logic [25:0] tmag;
   logic signed [31:0] calc, allowed, outv;
   logic [3:0]  cnt_use;

   cacc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .done  (ddone),
      .quo   (dquo)
   );

   assign eff        = (effm_ff > 10'd500) ? effm_ff : 10'd1000;
   assign req_tready = (st_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign tmag       = 26'(target_ff[15] ? -32'(target_ff) : 32'(target_ff)) * 26'd1000;

   always_comb begin
      since_in = since_ff; nextv_in = nextv_ff; blk_in = blk_ff; lastm_in = lastm_ff;
      cnt_in = cnt_ff; emg_in = emg_ff; sw_in = sw_ff; st_in = st_ff;
      epath_in = epath_ff; tneg_in = tneg_ff; mulb_in = mulb_ff; prod_in = prod_ff;
      rcmd_in = rcmd_ff; rsp_in = rsp_ff; rpw_in = rpw_ff; rn_in = rn_ff; rd_in = rd_ff;
      dreq = '0;
      snd = 1'b0;
      sval = '0;
      sclamp = '0;
      qs = '0;
      limit = '0;
      calc = '0;
      allowed = '0;
      outv = '0;
      cnt_use = cnt_ff;

      case (st_ff)
         S_IDLE: begin
            if (acc) begin
               rn_in = '0;
               rd_in = 1'b0;
               st_in = S_PRE;
            end
         end
         S_PRE: begin
            st_in = S_OUT;
            if (cur_ff > 16'(SWITCH_ON_CA)) since_in = now_ff;
            if (later(now_ff, since_in + 32'(SHUTDOWN_DELAY_MS)) && mode_ff[1]) sw_in = 1'b0;
            if ((mode_ff == 2'd3 || emg_ff) && later(now_ff, nextv_ff)) begin
               rcmd_in[0] = CMD_VOLTAGE;
               rsp_in[0]  = vset_ff;
               rpw_in[0]  = sw_in;
               rn_in      = 2'd1;
               nextv_in   = now_ff + 32'(VOLTAGE_PERIOD_MS);
            end
            epath_in = 1'b0;
            if (opt_ff[0] && urg_ff) begin
               emg_in   = 1'b1;
               epath_in = 1'b1;
               mulb_in  = upper_ff;
               st_in    = S_MUL;
            end else if (emg_ff && !urg_ff) begin
               snd = 1'b1;
               if (cur_ff < 16'(EMERGENCY_CLEAR_CA)) emg_in = 1'b0;
            end else if (mode_ff == 2'd3 && !later(blk_ff, now_ff)) begin
               if (volt_ff < reen_ff) cnt_use = 4'(COUNT_RELOAD);
               cnt_in = cnt_use;
               if (inv_ff) begin
                  snd    = 1'b1;
                  blk_in = now_ff + 32'(INVERTER_BLOCK_MS);
               end else if (later(stamp_ff, lastm_ff) && cnt_use != 4'd0) begin
                  lastm_in   = stamp_ff;
                  tneg_in    = target_ff[15];
                  dreq.start = 1'b1;
                  dreq.num   = DIV_NUM_W'(tmag);
                  dreq.den   = DIV_DEN_W'(eff);
                  st_in      = S_TDIV;
               end
            end
         end
         S_TDIV: begin
            if (ddone) st_in = S_LIM;
         end
         S_LIM: begin
            st_in = S_OUT;
            qs    = tneg_ff ? -28'(dquo) : 28'(dquo);
            limit = -28'(meter_ff) + 28'(opow_ff) + qs;
            if (opt_ff[1] && level_ff >= stop_ff) limit = '0;
            if (limit > $signed(28'(lower_ff))) begin
               if (opow_ff < lower_ff) cnt_in = cnt_ff - 4'd1;
               else cnt_in = 4'(COUNT_RELOAD);
               if (opow_ff < lower_ff && cnt_in == 4'd0) begin
                  snd = 1'b1;
               end else begin
                  mulb_in = (limit > $signed(28'(upper_ff))) ? upper_ff : limit[15:0];
                  st_in   = S_MUL;
               end
            end else begin
               snd = 1'b1;
            end
         end
         S_MUL: begin
            prod_in = 26'(eff) * 26'(mulb_ff);
            st_in   = S_CSTRT;
         end
         S_CSTRT: begin
            if (volt_ff == 16'd0) begin
               st_in = S_FIN;
            end else begin
               dreq.start = 1'b1;
               dreq.num   = (DIV_NUM_W'(prod_ff) << 3) + (DIV_NUM_W'(prod_ff) << 1);
               dreq.den   = volt_ff;
               st_in      = S_CDIV;
            end
         end
         S_CDIV: begin
            if (ddone) st_in = S_FIN;
         end
         S_FIN: begin
            calc    = (volt_ff == 16'd0) ? 32'sd65535 : 32'(dquo);
            allowed = 32'(bmslim_ff) - 32'(bmscur_ff) + 32'(cur_ff);
            outv    = (!epath_ff && allowed < calc) ? allowed : calc;
            snd     = 1'b1;
            sval    = outv;
            if (!epath_ff) blk_in = now_ff + 32'(2 * REQUEST_INTERVAL_MS);
            st_in   = S_OUT;
         end
         S_OUT: begin
            if (rn_ff == 2'd0) begin
               st_in = S_IDLE;
            end else if (rsp_tready) begin
               rd_in = 1'b1;
               if (rd_ff || rn_ff == 2'd1) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // current command: clamp, drive the switch, queue
      if (snd) begin
         sclamp = sval < 0 ? 16'd0 : (sval > 32'sd65535 ? 16'hFFFF : sval[15:0]);
         if (sclamp > 16'(SWITCH_ON_CA) && mode_ff[1]) begin
            sw_in    = 1'b1;
            since_in = now_ff;
         end
         rcmd_in[rn_in[0]] = CMD_CURRENT;
         rsp_in[rn_in[0]]  = sclamp;
         rpw_in[rn_in[0]]  = sw_in;
         rn_in             = rn_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         now_ff    <= req_tdata[31:0];
         volt_ff   <= req_tdata[47:32];
         cur_ff    <= req_tdata[63:48];
         opow_ff   <= req_tdata[79:64];
         effm_ff   <= req_tdata[89:80];
         meter_ff  <= req_tdata[113:90];
         stamp_ff  <= req_tdata[145:114];
         inv_ff    <= req_tdata[146];
         urg_ff    <= req_tdata[147];
         level_ff  <= req_tdata[154:148];
         bmslim_ff <= req_tdata[170:155];
         bmscur_ff <= req_tdata[187:171];
      end
      epath_ff <= epath_in;
      tneg_ff  <= tneg_in;
      mulb_ff  <= mulb_in;
      prod_ff  <= prod_in;
      rcmd_ff  <= rcmd_in;
      rsp_ff   <= rsp_in;
      rpw_ff   <= rpw_in;
      rd_ff    <= rd_in;
      if (reset) begin
         mode_ff <= '0; opt_ff <= '0; vset_ff <= '0; reen_ff <= '0;
         target_ff <= '0; lower_ff <= '0; upper_ff <= '0; stop_ff <= 7'd100;
         since_ff <= '0; nextv_ff <= '0; blk_ff <= '0; lastm_ff <= '0;
         cnt_ff <= '0; emg_ff <= 1'b0; sw_ff <= 1'b0;
         st_ff <= S_IDLE; rn_ff <= '0;
      end else begin
         since_ff <= since_in; nextv_ff <= nextv_in; blk_ff <= blk_in;
         lastm_ff <= lastm_in; cnt_ff <= cnt_in; emg_ff <= emg_in; sw_ff <= sw_in;
         st_ff <= st_in; rn_ff <= rn_in;
         if (csr_wen) begin
            case (csr_addr)
               CSR_MODE:     mode_ff   <= csr_wdata[1:0];
               CSR_OPTIONS:  opt_ff    <= csr_wdata[1:0];
               CSR_VSET:     vset_ff   <= csr_wdata;
               CSR_REEN_V:   reen_ff   <= csr_wdata;
               CSR_TARGET:   target_ff <= csr_wdata;
               CSR_LOWER:    lower_ff  <= csr_wdata;
               CSR_UPPER:    upper_ff  <= csr_wdata;
               CSR_STOP_LVL: stop_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = (st_ff == S_OUT) && (rn_ff != 2'd0);
   assign rsp_tdata  = {7'd0, rpw_ff[rd_ff], rsp_ff[rd_ff]};
   assign rsp_tuser  = rcmd_ff[rd_ff];
   assign rsp_tlast  = rd_ff || (rn_ff == 2'd1);

`ifndef SYNTH
   a_rn_max: assert property (@(posedge clock) disable iff (reset) rn_ff != 2'd3)
      else $error("result count overflow");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      ddone |-> (st_ff == S_TDIV || st_ff == S_CDIV))
      else $error("divider finished outside a wait state");
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> st_ff == S_IDLE)
      else $error("sequencer did not return to idle after last beat");
`endif
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the charger automatic current controller.
module testbench;
   import cacc_pkg::*;

   localparam int WATCHDOG_CYCLES = 5000;  // cycles with no beat on either side
   localparam int SETTLE_CYCLES   = 100;   // outlasts the longest tick
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int NUM_PHASES      = 8;
   localparam int NUM_ROWS        = 15;

   // one control tick as carried on req_tdata
   typedef struct {
      bit [31:0]        now;
      bit [15:0]        volt;
      bit [15:0]        cur;
      bit [15:0]        opow;
      bit [9:0]         eff;
      bit signed [23:0] meter;
      bit [31:0]        stamp;
      bit               inv;
      bit               urg;
      bit [6:0]         lvl;
      bit [15:0]        blim;
      bit signed [16:0] bcur;
   } tick_type;

   // one charger command as seen on the result channel
   typedef struct packed {
      logic        cmd;
      logic [15:0] setpoint;
      logic        power_on;
      logic        last;
   } charger_cmd_type;

   typedef struct {
      bit [1:0]         mode;
      bit [1:0]         opts;
      bit [15:0]        vset;
      bit [15:0]        reen;
      bit signed [15:0] target;
      bit [15:0]        lower;
      bit [15:0]        upper;
      bit [6:0]         stop;
      int               items;
   } setting_type;

   // directed row: n_typed < 0 means the predictor decides
   typedef struct {
      tick_type        t;
      int              n_typed;
      charger_cmd_type c0;
      charger_cmd_type c1;
   } row_type;

   logic         clock;
   logic         reset;
   logic [191:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_wen;
   logic [2:0]   csr_addr;
   logic [15:0]  csr_wdata;

   charger_auto_current_control u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // Predictor state: register copy plus controller timers and flags
   // ---------------------------------------------------------------------
   bit [1:0]         cfg_mode;
   bit [1:0]         cfg_opts;
   bit [15:0]        cfg_vset, cfg_reen, cfg_lower, cfg_upper;
   bit signed [15:0] cfg_target;
   bit [6:0]         cfg_stop;

   bit [31:0] on_since, next_vset_at, blocked_until, last_stamp;
   bit [3:0]  reen_count;
   bit        emergency, switch_on;

   charger_cmd_type tick_cmds[$];     // commands of the tick being predicted
   charger_cmd_type pending_cmds[$];  // commands still owed by the block

   int    errors = 0;
   tick_type offered;    // tick currently on req_tdata
   int    offered_typed; // typed command count of offered tick, or -1
   charger_cmd_type offered_c0, offered_c1;

   // a is after b, wrap-safe
   function automatic bit is_after(bit [31:0] a, bit [31:0] b);
      bit [31:0] d;
      d = a - b;
      return (d != 0) && !d[31];
   endfunction

   function automatic bit auto_mode();
      return cfg_mode == 2'd2 || cfg_mode == 2'd3;
   endfunction

   function automatic void emit_cmd(logic cmd, longint v);
      charger_cmd_type c;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      c.cmd = cmd;
      c.setpoint = v[15:0];
      c.power_on = switch_on;
      c.last = 1'b0;
      tick_cmds.push_back(c);
   endfunction

   function automatic void send_current(longint ca, bit [31:0] now);
      if (ca > 65535) ca = 65535;
      if (ca < 0) ca = 0;
      if (ca > SWITCH_ON_CA && auto_mode()) begin
         switch_on = 1'b1;
         on_since = now;
      end
      emit_cmd(CMD_CURRENT, ca);
   endfunction

   // centiamps from watts at a given efficiency and output voltage
   function automatic longint watts_to_ca(longint eff, longint pw, bit [15:0] volt);
      longint vd;
      vd = volt;
      if (vd == 0) return 65535;
      return eff * pw * 10 / vd;
   endfunction

   function automatic void run_tick(tick_type t);
      longint eff, lim, calc, allowed, lo, hi, opw, tg, blim, bcur, cur;
      eff  = (t.eff > 500) ? longint'(t.eff) : 1000;
      lo   = cfg_lower;
      hi   = cfg_upper;
      opw  = t.opow;
      tg   = cfg_target;
      blim = t.blim;
      bcur = t.bcur;
      cur  = t.cur;

      if (t.cur > SWITCH_ON_CA) on_since = t.now;
      if (is_after(t.now, on_since + 32'(SHUTDOWN_DELAY_MS)) && auto_mode())
         switch_on = 1'b0;

      // periodic voltage refresh
      if ((cfg_mode == 2'd3 || emergency) && is_after(t.now, next_vset_at)) begin
         emit_cmd(CMD_VOLTAGE, longint'(cfg_vset));
         next_vset_at = t.now + 32'(VOLTAGE_PERIOD_MS);
      end

      if (cfg_opts[0] && t.urg) begin
         emergency = 1'b1;
         send_current(watts_to_ca(eff, hi, t.volt), t.now);
         return;
      end
      if (emergency && !t.urg) begin
         send_current(0, t.now);
         if (t.cur < EMERGENCY_CLEAR_CA) emergency = 1'b0;
         return;
      end
      if (cfg_mode != 2'd3) return;
      if (is_after(blocked_until, t.now)) return;
      if (t.volt < cfg_reen) reen_count = 4'(COUNT_RELOAD);
      if (t.inv) begin
         send_current(0, t.now);
         blocked_until = t.now + 32'(INVERTER_BLOCK_MS);
         return;
      end
      if (!(is_after(t.stamp, last_stamp) && reen_count > 0)) return;
      last_stamp = t.stamp;

      lim = -longint'(t.meter) + opw + tg * 1000 / eff;
      if (cfg_opts[1] && t.lvl >= cfg_stop) lim = 0;

      if (lim > lo) begin
         if (t.opow < cfg_lower) begin
            reen_count = reen_count - 4'd1;
            if (reen_count == 0) begin
               send_current(0, t.now);
               return;
            end
         end else begin
            reen_count = 4'(COUNT_RELOAD);
         end
         if (lim > hi) lim = hi;
         calc = watts_to_ca(eff, lim, t.volt);
         allowed = blim - (bcur - cur);
         send_current((calc < allowed) ? calc : allowed, t.now);
         blocked_until = t.now + 32'(2 * REQUEST_INTERVAL_MS);
      end else begin
         send_current(0, t.now);
      end
   endfunction

   function automatic logic [191:0] pack_tick(tick_type t);
      return {4'b0, t.bcur, t.blim, t.lvl, t.urg, t.inv, t.stamp, t.meter,
              t.eff, t.opow, t.cur, t.volt, t.now};
   endfunction

   function automatic tick_type mk(bit [31:0] now, bit [15:0] volt, bit [15:0] cur,
                                   bit [15:0] opow, bit [9:0] eff, int meter,
                                   bit inv, bit urg, bit [6:0] lvl, bit [15:0] blim,
                                   int bcur);
      tick_type t;
      t.now = now; t.volt = volt; t.cur = cur; t.opow = opow; t.eff = eff;
      t.meter = meter[23:0]; t.stamp = now; t.inv = inv; t.urg = urg;
      t.lvl = lvl; t.blim = blim; t.bcur = bcur[16:0];
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: prediction on input beats, checking on output beats, watchdog
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      charger_cmd_type got, want;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            tick_cmds.delete();
            run_tick(offered);
            if (offered_typed >= 0) begin
               // directed row with hand-written commands; state still advances
               tick_cmds.delete();
               if (offered_typed > 0) tick_cmds.push_back(offered_c0);
               if (offered_typed > 1) tick_cmds.push_back(offered_c1);
            end
            if (tick_cmds.size() > 0) tick_cmds[tick_cmds.size()-1].last = 1'b1;
            foreach (tick_cmds[i]) pending_cmds.push_back(tick_cmds[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            got.cmd = rsp_tuser;
            got.setpoint = rsp_tdata[15:0];
            got.power_on = rsp_tdata[16];
            got.last = rsp_tlast;
            if (pending_cmds.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat cmd=%0d set=%0d on=%0d last=%0d",
                        $time, got.cmd, got.setpoint, got.power_on, got.last);
            end else begin
               want = pending_cmds.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch exp cmd=%0d set=%0d on=%0d last=%0d",
                           $time, want.cmd, want.setpoint, want.power_on, want.last);
                  $display("%0t:          got cmd=%0d set=%0d on=%0d last=%0d",
                           $time, got.cmd, got.setpoint, got.power_on, got.last);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog, %0d commands outstanding", $time,
                     pending_cmds.size());
            $display("charger_auto_current_control verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: randomly re-chosen stall pattern, plus long hold-off
   // ---------------------------------------------------------------------
   bit hold_req = 0;
   int hold_left = 0;
   int rx_cycle = 0;
   int rx_mode = 0;

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (rx_cycle % 3 != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   int burst_left = 0;
   bit [31:0] clock_ms = 32'd100;
   bit [31:0] stamp_sent = 32'd0;

   task automatic send_tick(tick_type t, int n_typed, charger_cmd_type c0,
                            charger_cmd_type c1);
      if (burst_left == 0) begin
         int gap;
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      offered = t;
      offered_typed = n_typed;
      offered_c0 = c0;
      offered_c1 = c1;
      req_tdata <= pack_tick(t);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      stamp_sent = t.stamp;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);  // a tick with no command may still run
   endtask

   task automatic apply_setting(setting_type s);
      bit [15:0] vals[8];
      bit [2:0]  addrs[8];
      cfg_mode = s.mode; cfg_opts = s.opts; cfg_vset = s.vset; cfg_reen = s.reen;
      cfg_target = s.target; cfg_lower = s.lower; cfg_upper = s.upper;
      cfg_stop = s.stop;
      addrs = '{CSR_MODE, CSR_OPTIONS, CSR_VSET, CSR_REEN_V, CSR_TARGET,
                CSR_LOWER, CSR_UPPER, CSR_STOP_LVL};
      vals = '{16'(s.mode), 16'(s.opts), s.vset, s.reen, s.target,
               s.lower, s.upper, 16'(s.stop)};
      for (int i = 0; i < 8; i++) begin
         csr_wen <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_wen <= 1'b0;
   endtask

   // random tick, mostly plausible readings so the regulation path is reached
   function automatic tick_type random_tick();
      tick_type t;
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)      clock_ms += $urandom_range(200, 3000);
      else if (r < 90) clock_ms += $urandom_range(3000, 20000);
      else if (r < 97) clock_ms += $urandom_range(60000, 90000);
      else             clock_ms += $urandom;
      t.now = clock_ms;
      r = $urandom_range(0, 99);
      t.volt = (r < 70) ? 16'($urandom_range(4000, 6000)) :
               (r < 88) ? 16'($urandom_range(3000, 4500)) :
               (r < 92) ? 16'd0 : (r < 95) ? 16'hFFFF : 16'($urandom);
      t.cur  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
      t.opow = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
      t.eff  = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(900, 970)) :
               10'($urandom_range(0, 1000));
      t.meter = ($urandom_range(0, 9) < 8) ? 24'($urandom_range(0, 8000) - 4000) :
                24'($urandom);
      r = $urandom_range(0, 9);
      t.stamp = (r < 8) ? t.now : (r < 9) ? stamp_sent : $urandom;
      t.inv  = ($urandom_range(0, 19) == 0);
      t.urg  = ($urandom_range(0, 19) == 0);
      t.lvl  = 7'($urandom_range(0, 100));
      t.blim = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(500, 5000)) : 16'($urandom);
      t.bcur = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, 5000) - 2000) :
               17'($urandom);
      return t;
   endfunction

   setting_type settings[NUM_PHASES];
   row_type     rows[NUM_ROWS];

   initial begin
      charger_cmd_type none;
      none = '0;
      // typical internal auto, then the other modes and register extremes
      settings[0] = '{2'd3, 2'd3, 16'd5600, 16'd4000, 16'sd0, 16'd50, 16'd3000, 7'd90, 150};
      settings[1] = '{2'd3, 2'd0, 16'd5400, 16'd4500, 16'sd100, 16'd100, 16'd2000, 7'd100, 180};
      settings[2] = '{2'd2, 2'd1, 16'd5800, 16'd4000, -16'sd50, 16'd0, 16'hFFFF, 7'd100, 140};
      settings[3] = '{2'd3, 2'd2, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'd0, 16'hFFFF, 7'd0, 150};
      settings[4] = '{2'd3, 2'd1, 16'd0, 16'd0, 16'sh8000, 16'hFFFF, 16'd0, 7'd100, 120};
      settings[5] = '{2'd1, 2'd3, 16'd5600, 16'd4000, 16'sd0, 16'd50, 16'd3000, 7'd50, 120};
      settings[6] = '{2'd0, 2'd1, 16'd5600, 16'd4000, 16'sd0, 16'd50, 16'd3000, 7'd100, 120};
      settings[7] = '{2'd3, 2'd3, 16'd5500, 16'd4200, -16'sd200, 16'd30, 16'd4000, 7'd80, 300};

      // directed ticks under setting 0, right after reset
      rows[0]  = '{mk(1000, 5000, 0, 0, 0, 0, 0, 1, 50, 3000, 0), 2,
                   '{CMD_VOLTAGE, 16'd5600, 1'b0, 1'b0}, '{CMD_CURRENT, 16'd6000, 1'b1, 1'b1}};
      // emergency ends, low current clears the flag
      rows[1]  = '{mk(2000, 5000, 50, 0, 0, 0, 0, 0, 50, 3000, 0), 1,
                   '{CMD_CURRENT, 16'd0, 1'b1, 1'b1}, none};
      // zero voltage saturates the current
      rows[2]  = '{mk(3000, 0, 0, 0, 0, 0, 0, 1, 50, 3000, 0), 1,
                   '{CMD_CURRENT, 16'hFFFF, 1'b1, 1'b1}, none};
      rows[3]  = '{mk(3500, 5000, 0, 0, 0, 0, 0, 0, 50, 3000, 0), 1,
                   '{CMD_CURRENT, 16'd0, 1'b1, 1'b1}, none};
      // inverter producing: zero current, then blocked for a second
      rows[4]  = '{mk(4000, 5000, 0, 0, 950, 0, 1, 0, 50, 3000, 0), 1,
                   '{CMD_CURRENT, 16'd0, 1'b1, 1'b1}, none};
      rows[5]  = '{mk(4500, 5000, 0, 0, 950, 0, 0, 0, 50, 3000, 0), 0, none, none};
      // regulation: low voltage reloads the counter, export gives a limit
      rows[6]  = '{mk(10000, 3900, 0, 0, 950, -2000, 0, 0, 50, 3000, 0), -1, none, none};
      // charge-level stop
      rows[7]  = '{mk(16000, 3900, 0, 500, 950, -2000, 0, 0, 95, 3000, 0), -1, none, none};
      // battery already full of current: negative result sent as zero
      rows[8]  = '{mk(17000, 3900, 0, 500, 950, -2000, 0, 0, 50, 0, 5000), -1, none, none};
      // efficiency at and just above the cut-over, meter extremes
      rows[9]  = '{mk(23000, 3900, 80, 100, 500, -8388608, 0, 0, 0, 65535, -65536),
                   -1, none, none};
      rows[10] = '{mk(29000, 65535, 0, 65535, 501, 8388607, 0, 0, 100, 65535, 65535),
                   -1, none, none};
      rows[11] = '{mk(35000, 3900, 0, 200, 1000, -1500, 0, 0, 10, 2000, 100), -1, none, none};
      // stale meter stamp
      rows[12] = '{mk(35000, 3900, 0, 200, 1000, -1500, 0, 0, 10, 2000, 100), -1, none, none};
      // long quiet stretch: switch drops, voltage refresh is due
      rows[13] = '{mk(200000, 5000, 0, 0, 960, 0, 0, 0, 10, 2000, 0), -1, none, none};
      // time near the wrap point
      rows[14] = '{mk(32'hFFFF_FFFF, 3900, 16'hFFFF, 1000, 10'h3FF, -3000, 0, 0, 127,
                      65535, 0), -1, none, none};
      rows[14].t.stamp = 32'hFFFF_FFFF;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_addr = CSR_MODE;
      csr_wdata = '0;
      offered_typed = -1;
      cfg_mode = 0; cfg_opts = 0; cfg_vset = 0; cfg_reen = 0; cfg_target = 0;
      cfg_lower = 0; cfg_upper = 0; cfg_stop = 7'd100;
      on_since = 0; next_vset_at = 0; blocked_until = 0; last_stamp = 0;
      reen_count = 0; emergency = 0; switch_on = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         go_idle();
         apply_setting(settings[p]);
         if (p == 0) begin
            foreach (rows[i]) send_tick(rows[i].t, rows[i].n_typed, rows[i].c0, rows[i].c1);
            clock_ms = 32'd210000;
         end
         if (p == NUM_PHASES - 1) clock_ms = 32'hFFF0_0000;  // run across the wrap
         for (int i = 0; i < settings[p].items; i++) begin
            if (p == 1 && i == 60) hold_req = 1;  // block backs up behind a stalled sink
            send_tick(random_tick(), -1, none, none);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0 && pending_cmds.size() == 0)
         $display("charger_auto_current_control verification clean");
      else
         $display("charger_auto_current_control verification failed");
      $finish;
   end
endmodule
